### sv/uoa_pkg.sv
// Shared types and constants of the ultrasonic obstacle avoider.
package uoa_pkg;

   // Step codes
   localparam logic [2:0] STEP_FWD     = 3'd0;
   localparam logic [2:0] STEP_RIGHT   = 3'd1;
   localparam logic [2:0] STEP_LEFT    = 3'd2;
   localparam logic [2:0] STEP_REVERSE = 3'd3;
   localparam logic [2:0] STEP_TURN    = 3'd4;
   localparam logic [2:0] STEP_SETTLE  = 3'd5;

   // Register indexes
   localparam logic [2:0] CSR_OBSTACLE_LIMIT = 3'd0;
   localparam logic [2:0] CSR_SCAN_DWELL_MS  = 3'd1;
   localparam logic [2:0] CSR_REVERSE_MS     = 3'd2;
   localparam logic [2:0] CSR_CRUISE_SPEED   = 3'd3;
   localparam logic [2:0] CSR_TURN_SPEED     = 3'd4;

   // Register reset values
   localparam logic [15:0] OBSTACLE_LIMIT_RST = 16'd480;
   localparam logic [15:0] SCAN_DWELL_MS_RST  = 16'd300;
   localparam logic [15:0] REVERSE_MS_RST     = 16'd1000;
   localparam logic [6:0]  CRUISE_SPEED_RST   = 7'd15;
   localparam logic [6:0]  TURN_SPEED_RST     = 7'd20;

   // Servo angles in degrees
   localparam logic [7:0] ANGLE_AHEAD = 8'd90;
   localparam logic [7:0] ANGLE_RIGHT = 8'd70;
   localparam logic [7:0] ANGLE_LEFT  = 8'd110;

   // Distance thresholds in 1/16 cm
   localparam logic signed [16:0] JUMP_HIGH   = 17'sd1600;
   localparam logic signed [16:0] JUMP_LOW    = 17'sd640;
   localparam logic signed [16:0] JUMP_FORCE  = 17'sd160;
   localparam logic signed [16:0] DIST_RST    = -17'sd16;

   // Divide by ten: q = (x * DIV10_MUL) >> DIV10_SHIFT, exact for x < 2^22
   localparam int             DIV10_SHIFT = 23;
   localparam logic [19:0]    DIV10_MUL   = 20'd838861;

   typedef struct packed {
      logic [15:0] obstacle_limit;
      logic [15:0] scan_dwell_ms;
      logic [15:0] reverse_ms;
      logic [6:0]  cruise_speed;
      logic [6:0]  turn_speed;
   } cfg_type;

   typedef struct packed {
      logic        motor_valid;
      logic [7:0]  left_speed;
      logic [7:0]  right_speed;
      logic        servo_valid;
      logic [7:0]  servo_angle;
      logic [2:0]  step_now;
   } rsp_type;

endpackage

### sv/ultrasonic_obstacle_avoider.sv
// Top level of the ultrasonic obstacle avoider: registers, handshakes and state.
//
//  channel   direction  tdata (low bit up)                        tuser
//  req_      in         time_ms[31:0], sample_dist[47:32]         restart
//  rsp_      out        motor_valid, left_speed, right_speed,     -
//                       servo_valid, servo_angle, step_now, pad
//  csr_      in         csr_wr_en / csr_index / csr_wdata         -
//
// One item per clock cycle sustained while rsp_ is not stalled; rsp_ valid is registered
// from the req_ item: it goes from the input register through filter and sequencer into the
// result register, and the step, timer and filter state update on the same edge.
// Reset (synchronous, active high) restores the registers and the filter state.
// A stalled rsp_ side holds the result; req_ takes one more item, then stalls.
module ultrasonic_obstacle_avoider (
   input  logic        clock,
   input  logic        reset,
   // time_ms[31:0], sample_dist[47:32]
   input  logic [47:0] req_tdata,
   // restart
   input  logic        req_tuser,
   input  logic        req_tvalid,
   output logic        req_tready,
   // motor_valid[0], left_speed[8:1], right_speed[16:9], servo_valid[17],
   // servo_angle[25:18], step_now[28:26], zero pad[31:29]
   output logic [31:0] rsp_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   uoa_pkg::cfg_type   cfg_ff;
   logic               in_valid_ff;
   logic [31:0]        in_time_ff;
   logic [15:0]        in_sample_ff;
   logic               in_restart_ff;
   logic               out_valid_ff;
   uoa_pkg::rsp_type   out_ff;
   logic [2:0]         step_ff;
   logic [2:0]         prev_step_ff;
   logic [31:0]        mark_ff;
   logic signed [16:0] filt_ff;
   logic signed [16:0] last_ff;

   logic               out_ready;
   logic               fire;
   logic               reseed;
   logic [31:0]        mark_start;
   logic signed [16:0] filt_in;
   logic signed [16:0] last_in;
   logic [2:0]         step_in;
   logic [31:0]        mark_in;
   uoa_pkg::rsp_type   rsp_in;

   // Handshake: the result register frees when taken, the input register when fired
   assign out_ready  = !out_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && out_ready;
   assign req_tready = !in_valid_ff || out_ready;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.obstacle_limit <= uoa_pkg::OBSTACLE_LIMIT_RST;
         cfg_ff.scan_dwell_ms  <= uoa_pkg::SCAN_DWELL_MS_RST;
         cfg_ff.reverse_ms     <= uoa_pkg::REVERSE_MS_RST;
         cfg_ff.cruise_speed   <= uoa_pkg::CRUISE_SPEED_RST;
         cfg_ff.turn_speed     <= uoa_pkg::TURN_SPEED_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            uoa_pkg::CSR_OBSTACLE_LIMIT: cfg_ff.obstacle_limit <= csr_wdata;
            uoa_pkg::CSR_SCAN_DWELL_MS:  cfg_ff.scan_dwell_ms  <= csr_wdata;
            uoa_pkg::CSR_REVERSE_MS:     cfg_ff.reverse_ms     <= csr_wdata;
            uoa_pkg::CSR_CRUISE_SPEED:   cfg_ff.cruise_speed   <= csr_wdata[6:0];
            uoa_pkg::CSR_TURN_SPEED:     cfg_ff.turn_speed     <= csr_wdata[6:0];
            default: begin
            end
         endcase
      end
   end

   // Capture the input item
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_time_ff    <= req_tdata[31:0];
         in_sample_ff  <= req_tdata[47:32];
         in_restart_ff <= req_tuser;
      end
   end

   // Restart marks the timer; a restart or a step change reseeds the filter
   always_comb begin
      mark_start = in_restart_ff ? in_time_ff : mark_ff;
      reseed     = in_restart_ff || (prev_step_ff != step_ff);
   end

   uoa_dist_filter u_filter (
      .reseed      (reseed),
      .sample_dist (in_sample_ff),
      .filt_cur    (filt_ff),
      .last_cur    (last_ff),
      .filt_new    (filt_in),
      .last_new    (last_in)
   );

   uoa_step_ctrl u_step (
      .cfg       (cfg_ff),
      .step_cur  (step_ff),
      .mark_cur  (mark_start),
      .time_ms   (in_time_ff),
      .filt_dist (filt_in),
      .step_new  (step_in),
      .mark_new  (mark_in),
      .rsp       (rsp_in)
   );

   // Advance state on each fired item
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= uoa_pkg::STEP_FWD;
         prev_step_ff <= uoa_pkg::STEP_FWD;
         mark_ff      <= 32'd0;
         filt_ff      <= uoa_pkg::DIST_RST;
         last_ff      <= uoa_pkg::DIST_RST;
      end else if (fire) begin
         step_ff      <= step_in;
         prev_step_ff <= step_ff;
         mark_ff      <= mark_in;
         filt_ff      <= filt_in;
         last_ff      <= last_in;
      end
   end

   // Hold the result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'd0, out_ff.step_now, out_ff.servo_angle, out_ff.servo_valid,
                        out_ff.right_speed, out_ff.left_speed, out_ff.motor_valid};

endmodule

### sv/uoa_dist_filter.sv
// Distance filter: reseed, jump clamp and (3*old + 7*sample)/10 update.
module uoa_dist_filter (
   input  logic               reseed,
   input  logic [15:0]        sample_dist,
   input  logic signed [16:0] filt_cur,
   input  logic signed [16:0] last_cur,
   output logic signed [16:0] filt_new,
   output logic signed [16:0] last_new
);

   logic signed [16:0] smp;
   logic signed [16:0] old;
   logic signed [20:0] sum;
   logic               sum_neg;
   logic [19:0]        mag;
   logic [39:0]        prod;
   logic [16:0]        quot;
   logic signed [16:0] avg;

   // Pick the starting value, reseeded with the raw sample on a restart or a new step
   always_comb begin
      smp = {1'b0, sample_dist};
      old = reseed ? smp : filt_cur;
   end

   // Weighted sum and truncating divide by ten on the magnitude
   always_comb begin
      sum     = 21'(3 * 21'(old)) + 21'(7 * 21'(smp));
      sum_neg = sum[20];
      mag     = sum_neg ? 20'(-sum) : sum[19:0];
      prod    = 40'(mag) * 40'(uoa_pkg::DIV10_MUL);
      quot    = prod[uoa_pkg::DIV10_SHIFT +: 17];
      avg     = sum_neg ? -$signed(quot) : $signed(quot);
   end

   // Update on a changed sample; clamp a sudden far jump after a near reading
   always_comb begin
      filt_new = old;
      last_new = last_cur;
      if (last_cur != smp) begin
         if (smp > uoa_pkg::JUMP_HIGH && last_cur < uoa_pkg::JUMP_LOW) begin
            filt_new = uoa_pkg::JUMP_FORCE;
         end else begin
            filt_new = avg;
            last_new = smp;
         end
      end
   end

endmodule

### sv/uoa_step_ctrl.sv
// Step sequencer: dwell timing, next step and motor and servo commands.
module uoa_step_ctrl (
   input  uoa_pkg::cfg_type    cfg,
   input  logic [2:0]          step_cur,
   input  logic [31:0]         mark_cur,
   input  logic [31:0]         time_ms,
   input  logic signed [16:0]  filt_dist,
   output logic [2:0]          step_new,
   output logic [31:0]         mark_new,
   output uoa_pkg::rsp_type    rsp
);

   logic        obstacle;
   logic [31:0] elapsed;
   logic        scan_done;
   logic        rev_done;
   logic [7:0]  cr;
   logic [7:0]  tr;

   // Obstacle test and wrapping dwell timers
   always_comb begin
      obstacle  = filt_dist < $signed({1'b0, cfg.obstacle_limit});
      elapsed   = time_ms - mark_cur;
      scan_done = elapsed > {16'd0, cfg.scan_dwell_ms};
      rev_done  = elapsed > {16'd0, cfg.reverse_ms};
      cr        = {1'b0, cfg.cruise_speed};
      tr        = {1'b0, cfg.turn_speed};
   end

   // Decide the step and the commands
   always_comb begin
      step_new        = step_cur;
      mark_new        = mark_cur;
      rsp.motor_valid = 1'b0;
      rsp.left_speed  = 8'd0;
      rsp.right_speed = 8'd0;
      rsp.servo_valid = 1'b0;
      rsp.servo_angle = 8'd0;
      case (step_cur)
         uoa_pkg::STEP_FWD: begin
            rsp.servo_valid = 1'b1;
            rsp.servo_angle = uoa_pkg::ANGLE_AHEAD;
            if (scan_done) begin
               rsp.motor_valid = 1'b1;
               if (obstacle) begin
                  step_new = uoa_pkg::STEP_RIGHT;
                  mark_new = time_ms;
               end else begin
                  rsp.left_speed  = cr;
                  rsp.right_speed = cr;
               end
            end
         end
         uoa_pkg::STEP_RIGHT: begin
            rsp.servo_valid = 1'b1;
            rsp.servo_angle = uoa_pkg::ANGLE_RIGHT;
            if (scan_done) begin
               if (obstacle) begin
                  step_new = uoa_pkg::STEP_LEFT;
                  mark_new = time_ms;
               end else begin
                  rsp.motor_valid = 1'b1;
                  rsp.left_speed  = tr;
                  rsp.right_speed = 8'(-tr);
                  step_new        = uoa_pkg::STEP_SETTLE;
               end
            end
         end
         uoa_pkg::STEP_LEFT: begin
            rsp.servo_valid = 1'b1;
            rsp.servo_angle = uoa_pkg::ANGLE_LEFT;
            if (scan_done) begin
               if (obstacle) begin
                  step_new = uoa_pkg::STEP_REVERSE;
                  mark_new = time_ms;
               end else begin
                  rsp.motor_valid = 1'b1;
                  rsp.left_speed  = 8'(-tr);
                  rsp.right_speed = tr;
                  step_new        = uoa_pkg::STEP_SETTLE;
               end
            end
         end
         uoa_pkg::STEP_REVERSE: begin
            rsp.servo_valid = 1'b1;
            rsp.servo_angle = uoa_pkg::ANGLE_AHEAD;
            rsp.motor_valid = 1'b1;
            rsp.left_speed  = 8'(-cr);
            rsp.right_speed = 8'(-cr);
            if (rev_done) begin
               step_new = uoa_pkg::STEP_TURN;
               mark_new = time_ms;
            end
         end
         uoa_pkg::STEP_TURN: begin
            rsp.motor_valid = 1'b1;
            rsp.left_speed  = tr;
            rsp.right_speed = 8'(-tr);
            step_new        = uoa_pkg::STEP_SETTLE;
         end
         uoa_pkg::STEP_SETTLE: begin
            if (scan_done) begin
               step_new = uoa_pkg::STEP_FWD;
               mark_new = time_ms;
            end
         end
         default: begin
            step_new = step_cur;
         end
      endcase
      rsp.step_now = step_new;
   end

endmodule

### verif/testbench.sv
// Self-checking testbench for the ultrasonic obstacle avoider: step walk, filter and traffic.
`timescale 1ns / 100ps

module testbench;

   localparam int WATCHDOG_CYCLES = 3000;
   localparam int MAX_REPORTS     = 10;

   // Clock, reset and block ports
   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic [47:0] req_tdata   = '0;
   logic        req_tuser   = 1'b0;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [31:0] rsp_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b1;
   logic        csr_wr_en   = 1'b0;
   logic [2:0]  csr_index   = '0;
   logic [15:0] csr_wdata   = '0;

   // Shadow copy of the avoider state and its registers
   logic [2:0]        step_q;
   logic [2:0]        prev_step_q;
   logic [31:0]       mark_q;
   int                filt_q;
   int                last_smp_q;
   uoa_pkg::cfg_type  cfg_q;

   // Commands still owed by the block, oldest first
   uoa_pkg::rsp_type  expected_cmds[$];
   int                mismatches     = 0;

   // Idling control and random scene state
   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   logic [31:0] now_ms         = '0;
   logic [15:0] prev_echo      = '0;
   logic        near_scene     = 1'b0;

   ultrasonic_obstacle_avoider u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),   // time_ms[31:0], sample_dist[47:32]
      .req_tuser  (req_tuser),   // restart
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),   // motor_valid, left, right, servo_valid, angle, step, pad
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Restore the shadow state to its reset values
   task automatic reset_avoider_state();
      step_q      = uoa_pkg::STEP_FWD;
      prev_step_q = uoa_pkg::STEP_FWD;
      mark_q      = '0;
      filt_q      = int'(uoa_pkg::DIST_RST);
      last_smp_q  = int'(uoa_pkg::DIST_RST);
      cfg_q.obstacle_limit = uoa_pkg::OBSTACLE_LIMIT_RST;
      cfg_q.scan_dwell_ms  = uoa_pkg::SCAN_DWELL_MS_RST;
      cfg_q.reverse_ms     = uoa_pkg::REVERSE_MS_RST;
      cfg_q.cruise_speed   = uoa_pkg::CRUISE_SPEED_RST;
      cfg_q.turn_speed     = uoa_pkg::TURN_SPEED_RST;
   endtask

   // Advance the shadow state by one item and produce the commands it issues
   task automatic advance_avoider(input logic [31:0] now, input logic [15:0] echo_len,
                                  input logic restart, output uoa_pkg::rsp_type cmd);
      int          smp;
      int          cr;
      int          tr;
      logic        obstacle;
      logic [31:0] elapsed;
      smp = int'(echo_len);
      cr  = int'(cfg_q.cruise_speed);
      tr  = int'(cfg_q.turn_speed);
      cmd = '0;

      // Reseed timer and filter on mode entry, reseed filter on a step change
      if (restart) begin
         mark_q      = now;
         prev_step_q = uoa_pkg::STEP_FWD;
         filt_q      = smp;
      end
      if (prev_step_q != step_q) begin
         prev_step_q = step_q;
         filt_q      = smp;
      end

      // Filter a new sample, or force a short reading on a far jump
      if (last_smp_q != smp) begin
         if (smp > int'(uoa_pkg::JUMP_HIGH) && last_smp_q < int'(uoa_pkg::JUMP_LOW)) begin
            filt_q = int'(uoa_pkg::JUMP_FORCE);
         end else begin
            filt_q     = (3 * filt_q + 7 * smp) / 10;
            last_smp_q = smp;
         end
      end

      obstacle = filt_q < int'(cfg_q.obstacle_limit);
      elapsed  = now - mark_q;

      case (step_q)
         uoa_pkg::STEP_FWD: begin
            cmd.servo_valid = 1'b1;
            cmd.servo_angle = uoa_pkg::ANGLE_AHEAD;
            if (elapsed > 32'(cfg_q.scan_dwell_ms)) begin
               cmd.motor_valid = 1'b1;
               if (obstacle) begin
                  step_q = uoa_pkg::STEP_RIGHT;
                  mark_q = now;
               end else begin
                  cmd.left_speed  = 8'(cr);
                  cmd.right_speed = 8'(cr);
               end
            end
         end
         uoa_pkg::STEP_RIGHT: begin
            cmd.servo_valid = 1'b1;
            cmd.servo_angle = uoa_pkg::ANGLE_RIGHT;
            if (elapsed > 32'(cfg_q.scan_dwell_ms)) begin
               if (obstacle) begin
                  step_q = uoa_pkg::STEP_LEFT;
                  mark_q = now;
               end else begin
                  cmd.motor_valid = 1'b1;
                  cmd.left_speed  = 8'(tr);
                  cmd.right_speed = 8'(-tr);
                  step_q = uoa_pkg::STEP_SETTLE;
               end
            end
         end
         uoa_pkg::STEP_LEFT: begin
            cmd.servo_valid = 1'b1;
            cmd.servo_angle = uoa_pkg::ANGLE_LEFT;
            if (elapsed > 32'(cfg_q.scan_dwell_ms)) begin
               if (obstacle) begin
                  step_q = uoa_pkg::STEP_REVERSE;
                  mark_q = now;
               end else begin
                  cmd.motor_valid = 1'b1;
                  cmd.left_speed  = 8'(-tr);
                  cmd.right_speed = 8'(tr);
                  step_q = uoa_pkg::STEP_SETTLE;
               end
            end
         end
         uoa_pkg::STEP_REVERSE: begin
            cmd.servo_valid = 1'b1;
            cmd.servo_angle = uoa_pkg::ANGLE_AHEAD;
            cmd.motor_valid = 1'b1;
            cmd.left_speed  = 8'(-cr);
            cmd.right_speed = 8'(-cr);
            if (elapsed > 32'(cfg_q.reverse_ms)) begin
               step_q = uoa_pkg::STEP_TURN;
               mark_q = now;
            end
         end
         uoa_pkg::STEP_TURN: begin
            cmd.motor_valid = 1'b1;
            cmd.left_speed  = 8'(tr);
            cmd.right_speed = 8'(-tr);
            step_q = uoa_pkg::STEP_SETTLE;
         end
         uoa_pkg::STEP_SETTLE: begin
            if (elapsed > 32'(cfg_q.scan_dwell_ms)) begin
               step_q = uoa_pkg::STEP_FWD;
               mark_q = now;
            end
         end
         default: ;
      endcase
      cmd.step_now = step_q;
   endtask

   // Offer one item, with random idle cycles ahead of it, and log its commands
   task automatic send_item(input logic [31:0] now, input logic [15:0] echo_len,
                            input logic restart);
      uoa_pkg::rsp_type cmd;
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tdata  <= {echo_len, now};
      req_tuser  <= restart;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      advance_avoider(now, echo_len, restart, cmd);
      expected_cmds.push_back(cmd);
   endtask

   // Drop valid and hold until every command has come back and the pipe is empty
   task automatic drain_commands(input int extra_cycles);
      req_tvalid <= 1'b0;
      while (expected_cmds.size() != 0) @(posedge clock);
      repeat (extra_cycles) @(posedge clock);
   endtask

   // Write one register and mirror it in the shadow copy
   task automatic csr_write(input logic [2:0] idx, input logic [15:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         uoa_pkg::CSR_OBSTACLE_LIMIT: cfg_q.obstacle_limit = value;
         uoa_pkg::CSR_SCAN_DWELL_MS:  cfg_q.scan_dwell_ms  = value;
         uoa_pkg::CSR_REVERSE_MS:     cfg_q.reverse_ms     = value;
         uoa_pkg::CSR_CRUISE_SPEED:   cfg_q.cruise_speed   = value[6:0];
         uoa_pkg::CSR_TURN_SPEED:     cfg_q.turn_speed     = value[6:0];
         default: ;
      endcase
   endtask

   // Load a full register set while the block is idle
   task automatic load_settings(input logic [15:0] limit, input logic [15:0] dwell,
                                input logic [15:0] rev, input logic [15:0] cruise,
                                input logic [15:0] turn);
      drain_commands(4);
      csr_write(uoa_pkg::CSR_OBSTACLE_LIMIT, limit);
      csr_write(uoa_pkg::CSR_SCAN_DWELL_MS, dwell);
      csr_write(uoa_pkg::CSR_REVERSE_MS, rev);
      csr_write(uoa_pkg::CSR_CRUISE_SPEED, cruise);
      csr_write(uoa_pkg::CSR_TURN_SPEED, turn);
      csr_wr_en <= 1'b0;
   endtask

   // Drive a car through a scene of near and far objects, with some noise
   task automatic drive_scene(input int count);
      logic [15:0] echo_len;
      int          pick;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 2)
            now_ms = $urandom();
         else if (pick < 6)
            now_ms += $urandom_range(0, 200000);
         else if (pick < 20)
            now_ms += $urandom_range(0, 1200);
         else
            now_ms += $urandom_range(0, 150);
         if ($urandom_range(99) < 10) near_scene = ~near_scene;
         pick = $urandom_range(99);
         if (pick < 3)
            echo_len = 16'($urandom_range(0, 65535));
         else if (pick < 15)
            echo_len = prev_echo;
         else if (near_scene)
            echo_len = 16'($urandom_range(60, 700));
         else
            echo_len = 16'($urandom_range(500, 2400));
         prev_echo = echo_len;
         send_item(now_ms, echo_len, $urandom_range(99) < 3);
      end
   endtask

   // Walk every step by hand, with the far jump, restart and time wrap
   task automatic test_directed_walk();
      send_item(32'd0,    16'd0,     1'b0);
      send_item(32'd301,  16'd65535, 1'b0);
      send_item(32'd400,  16'd2000,  1'b0);
      send_item(32'd700,  16'd1600,  1'b0);
      send_item(32'd1000, 16'd1600,  1'b0);
      send_item(32'd1100, 16'd1600,  1'b0);
      send_item(32'd1301, 16'd1600,  1'b0);
      send_item(32'd1302, 16'd200,   1'b0);
      send_item(32'd1303, 16'd200,   1'b0);
      send_item(32'd1304, 16'd100,   1'b0);
      send_item(32'd1700, 16'd100,   1'b0);
      send_item(32'd2001, 16'd100,   1'b0);
      send_item(32'd2500, 16'd100,   1'b0);
      send_item(32'd3002, 16'd100,   1'b0);
      send_item(32'd3003, 16'd100,   1'b0);
      send_item(32'd3304, 16'd100,   1'b0);
      send_item(32'hFFFF_FF00, 16'd5000, 1'b1);
      send_item(32'h0000_0040, 16'd5000, 1'b0);
      send_item(32'h0000_0180, 16'd100,  1'b0);
      send_item(32'h0000_02C0, 16'd1000, 1'b0);
      send_item(32'h0000_02C1, 16'd1000, 1'b1);
      send_item(32'hFFFF_FFFF, 16'd0,    1'b0);
      now_ms = 32'd0;
   endtask

   task automatic test_steady_traffic();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      drive_scene(170);
   endtask

   task automatic test_sender_gaps();
      load_settings(16'd800, 16'd40, 16'd120, 16'd100, 16'd100);
      send_idle_pct  = 86;
      recv_stall_pct = 0;
      drive_scene(160);
   endtask

   task automatic test_receiver_stalls();
      load_settings(16'd1200, 16'd300, 16'd700, 16'd127, 16'd127);
      send_idle_pct  = 0;
      recv_stall_pct = 86;
      drive_scene(160);
   endtask

   task automatic test_mixed_idling();
      load_settings(16'd600, 16'd150, 16'd400, 16'd33, 16'd64);
      send_idle_pct  = 20;
      recv_stall_pct = 20;
      drive_scene(160);
   endtask

   task automatic test_register_extremes();
      load_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      drive_scene(90);
      load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd127, 16'd1);
      send_idle_pct  = 20;
      recv_stall_pct = 20;
      drive_scene(90);
   endtask

   // Randomly stall the result side
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic report_mismatch(input string field, input logic [31:0] want,
                                  input logic [31:0] got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("mismatch at %0t: %s expected %0d got %0d", $realtime, field, want, got);
   endtask

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) report_mismatch(field, want, got);
   endtask

   // Compare each returned item with the oldest owed command
   always @(posedge clock) begin : check_results
      uoa_pkg::rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_cmds.size() == 0) begin
            report_mismatch("unexpected item", 32'd0, rsp_tdata);
         end else begin
            want = expected_cmds.pop_front();
            check_field("motor_valid", 32'(want.motor_valid), 32'(rsp_tdata[0]));
            check_field("left_speed",  32'(want.left_speed),  32'(rsp_tdata[8:1]));
            check_field("right_speed", 32'(want.right_speed), 32'(rsp_tdata[16:9]));
            check_field("servo_valid", 32'(want.servo_valid), 32'(rsp_tdata[17]));
            check_field("servo_angle", 32'(want.servo_angle), 32'(rsp_tdata[25:18]));
            check_field("step_now",    32'(want.step_now),    32'(rsp_tdata[28:26]));
            check_field("pad",         32'd0,                 32'(rsp_tdata[31:29]));
         end
      end
   end

   // End the run when no item moves for too long
   always @(posedge clock) begin : watchdog
      int quiet_cycles;
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   initial begin
      reset_avoider_state();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed_walk();
      test_steady_traffic();
      test_sender_gaps();
      test_receiver_stalls();
      test_mixed_idling();
      test_register_extremes();
      drain_commands(8);
      if (mismatches == 0 && expected_cmds.size() == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule
